### src/hptd_pkg.sv
// ----------------------------------------------------------------------------
// hptd_pkg
// Shared constants and controller/datapath interface types for the
// parent-table Huffman decoder.
// ----------------------------------------------------------------------------
package hptd_pkg;

    localparam int ALPHABET_SIZE = 256;
    localparam int WALK_LIMIT    = 256;
    localparam int TABLE_DEPTH   = 2 * ALPHABET_SIZE - 1;
    localparam int STEP_W        = $clog2(WALK_LIMIT + 1);

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_BUILD = 2'd1;
    localparam logic [1:0] REQ_DATA  = 2'd2;
    localparam logic [1:0] REQ_RSVD  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SELF  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_LIMIT = 2'd3;

    localparam logic [7:0] NO_PARENT = 8'd255;
    localparam logic [7:0] ROOT_SLOT = 8'd255;

    typedef struct packed {
        logic       take_in;
        logic       clear_valid;
        logic       leaf_init;
        logic       leaf_rd;
        logic       leaf_next;
        logic       chain_start;
        logic       step_rd;
        logic       step_ev;
        logic       root_rd;
        logic       root_wr;
        logic       set_status;
        logic [1:0] status;
        logic       finish;
        logic       dec_start;
        logic       dec_step;
        logic       dec_emit;
    } hptd_cmd_t;

    typedef struct packed {
        logic ptab_none;
        logic self_parent;
        logic leaf_last;
        logic limit_hit;
        logic any_leaf;
        logic dec_ready;
        logic dec_leaf;
        logic dec_final;
        logic sym_one;
        logic out_free;
    } hptd_stat_t;

endpackage

### src/hptd_ctrl.sv
// ----------------------------------------------------------------------------
// hptd_ctrl
// Sequencer for table load, tree build walk and bit-serial decode.
// ----------------------------------------------------------------------------
module hptd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic [1:0]           req_type,
    input  hptd_pkg::hptd_stat_t stat,
    output hptd_pkg::hptd_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CLR      = 4'd1;
    localparam logic [3:0] S_LEAF_RD  = 4'd2;
    localparam logic [3:0] S_LEAF_CHK = 4'd3;
    localparam logic [3:0] S_STEP_RD  = 4'd4;
    localparam logic [3:0] S_STEP_EV  = 4'd5;
    localparam logic [3:0] S_ROOT_RD  = 4'd6;
    localparam logic [3:0] S_ROOT_WR  = 4'd7;
    localparam logic [3:0] S_FIN      = 4'd8;
    localparam logic [3:0] S_DEC_RD   = 4'd9;
    localparam logic [3:0] S_DEC_BIT  = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.take_in = 1'b1;
                    if (req_type == hptd_pkg::REQ_BUILD)
                    begin
                        state_next = S_CLR;
                    end
                    else if (req_type == hptd_pkg::REQ_DATA && stat.dec_ready)
                    begin
                        cmd.dec_start = 1'b1;
                        state_next    = S_DEC_RD;
                    end
                end
            end
            S_CLR:
            begin
                cmd.clear_valid = 1'b1;
                cmd.leaf_init   = 1'b1;
                state_next      = S_LEAF_RD;
            end
            S_LEAF_RD:
            begin
                cmd.leaf_rd = 1'b1;
                state_next  = S_LEAF_CHK;
            end
            S_LEAF_CHK:
            begin
                if (!stat.ptab_none)
                begin
                    cmd.chain_start = 1'b1;
                    state_next      = S_STEP_RD;
                end
                else if (stat.leaf_last)
                begin
                    state_next = S_ROOT_RD;
                end
                else
                begin
                    cmd.leaf_next = 1'b1;
                    state_next    = S_LEAF_RD;
                end
            end
            S_STEP_RD:
            begin
                if (stat.limit_hit)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = hptd_pkg::ST_LIMIT;
                    state_next     = S_FIN;
                end
                else
                begin
                    cmd.step_rd = 1'b1;
                    state_next  = S_STEP_EV;
                end
            end
            S_STEP_EV:
            begin
                cmd.step_ev = 1'b1;
                if (stat.self_parent)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = hptd_pkg::ST_SELF;
                    state_next     = S_FIN;
                end
                else if (!stat.ptab_none)
                begin
                    state_next = S_STEP_RD;
                end
                else if (stat.leaf_last)
                begin
                    state_next = S_ROOT_RD;
                end
                else
                begin
                    cmd.leaf_next = 1'b1;
                    state_next    = S_LEAF_RD;
                end
            end
            S_ROOT_RD:
            begin
                if (!stat.any_leaf)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = hptd_pkg::ST_EMPTY;
                    state_next     = S_FIN;
                end
                else
                begin
                    cmd.root_rd = 1'b1;
                    state_next  = S_ROOT_WR;
                end
            end
            S_ROOT_WR:
            begin
                cmd.root_wr    = 1'b1;
                cmd.set_status = 1'b1;
                cmd.status     = hptd_pkg::ST_OK;
                state_next     = S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DEC_RD:
            begin
                state_next = S_DEC_BIT;
            end
            S_DEC_BIT:
            begin
                if (!stat.dec_leaf || stat.out_free)
                begin
                    cmd.dec_step = 1'b1;
                    cmd.dec_emit = stat.dec_leaf;
                    if (stat.dec_final || (stat.dec_leaf && stat.sym_one))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### src/hptd_datapath.sv
// ----------------------------------------------------------------------------
// hptd_datapath
// Parent table and child-pair memories, walk registers and result register.
// ----------------------------------------------------------------------------
module hptd_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hptd_pkg::hptd_cmd_t  cmd,
    output hptd_pkg::hptd_stat_t stat,
    input  logic [1:0]           req_type,
    input  logic [8:0]           entry_index,
    input  logic [7:0]           payload_byte,
    input  logic [30:0]          symbol_total,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic                 result_kind,
    output logic [7:0]           symbol,
    output logic [1:0]           build_status,
    output logic                 last
);

    logic [7:0]  ptab_mem [hptd_pkg::TABLE_DEPTH];
    logic [17:0] cmem [hptd_pkg::ALPHABET_SIZE];
    logic [hptd_pkg::ALPHABET_SIZE-1:0] cvalid_reg;

    logic [7:0]  ptab_q;
    logic [17:0] cmem_q;
    logic        cvalid_q;

    logic [7:0]  leaf_reg;
    logic [7:0]  v_reg;
    logic [8:0]  prev_reg;
    logic [hptd_pkg::STEP_W-1:0] steps_reg;
    logic [7:0]  root_reg;
    logic        any_reg;
    logic [1:0]  status_reg;
    logic        tree_ready_reg;
    logic [30:0] sym_left_reg;
    logic [7:0]  walk_node_reg;
    logic [7:0]  byte_reg;
    logic [30:0] total_reg;
    logic [2:0]  bit_reg;

    logic        out_valid_reg;
    logic        out_kind_reg;
    logic [7:0]  out_sym_reg;
    logic [1:0]  out_st_reg;
    logic        out_last_reg;

    logic [8:0]  ptab_ra;
    logic [7:0]  cmem_ra;
    logic [7:0]  cmem_wa;
    logic [17:0] cmem_wd;
    logic        cmem_we;
    logic [8:0]  s0;
    logic [8:0]  s1;
    logic [8:0]  dec_child;
    logic [7:0]  dec_next;
    logic        load_we;
    logic        out_free;

    assign s0        = cvalid_q ? cmem_q[8:0]  : 9'd0;
    assign s1        = cvalid_q ? cmem_q[17:9] : 9'd0;
    assign dec_child = byte_reg[bit_reg] ? s1 : s0;
    assign dec_next  = dec_child[8] ? dec_child[7:0] : hptd_pkg::ROOT_SLOT;
    assign out_free  = !out_valid_reg || res_ready;
    assign load_we   = cmd.take_in && (req_type == hptd_pkg::REQ_LOAD)
                       && (entry_index < 9'(hptd_pkg::TABLE_DEPTH));

    assign stat.ptab_none   = (ptab_q == hptd_pkg::NO_PARENT);
    assign stat.self_parent = (ptab_q == v_reg);
    assign stat.leaf_last   = (leaf_reg == 8'd255);
    assign stat.limit_hit   = (steps_reg >= hptd_pkg::STEP_W'(hptd_pkg::WALK_LIMIT));
    assign stat.any_leaf    = any_reg;
    assign stat.dec_ready   = tree_ready_reg && (sym_left_reg != 31'd0);
    assign stat.dec_leaf    = !dec_child[8];
    assign stat.dec_final   = (bit_reg == 3'd7);
    assign stat.sym_one     = (sym_left_reg == 31'd1);
    assign stat.out_free    = out_free;

    always_comb
    begin
        ptab_ra = cmd.step_rd ? {1'b1, v_reg} : {1'b0, leaf_reg};
        if (cmd.step_rd)
        begin
            cmem_ra = v_reg;
        end
        else if (cmd.root_rd)
        begin
            cmem_ra = root_reg;
        end
        else if (cmd.dec_step)
        begin
            cmem_ra = dec_next;
        end
        else
        begin
            cmem_ra = walk_node_reg;
        end
        cmem_we = cmd.step_ev || cmd.root_wr;
        cmem_wa = cmd.root_wr ? hptd_pkg::ROOT_SLOT : v_reg;
        if (cmd.root_wr)
        begin
            cmem_wd = {s1, s0};
        end
        else if (!cvalid_q)
        begin
            cmem_wd = {9'd0, prev_reg};
        end
        else if (s0 != prev_reg)
        begin
            cmem_wd = {prev_reg, s0};
        end
        else
        begin
            cmem_wd = {s1, prev_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            ptab_mem[entry_index] <= payload_byte;
        end
        ptab_q <= ptab_mem[ptab_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cmem_we)
        begin
            cmem[cmem_wa] <= cmem_wd;
        end
        cmem_q <= cmem[cmem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cvalid_reg <= '0;
            cvalid_q   <= 1'b0;
        end
        else
        begin
            cvalid_q <= cvalid_reg[cmem_ra];
            if (cmd.clear_valid)
            begin
                cvalid_reg <= '0;
            end
            else if (cmem_we)
            begin
                cvalid_reg[cmem_wa] <= cmd.root_wr ? cvalid_q : 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            byte_reg  <= payload_byte;
            total_reg <= symbol_total;
        end
        if (cmd.leaf_init)
        begin
            leaf_reg <= 8'd0;
            any_reg  <= 1'b0;
        end
        else if (cmd.leaf_next)
        begin
            leaf_reg <= leaf_reg + 8'd1;
        end
        if (cmd.chain_start)
        begin
            v_reg     <= ptab_q;
            prev_reg  <= {1'b0, leaf_reg};
            steps_reg <= '0;
            any_reg   <= 1'b1;
        end
        if (cmd.step_rd)
        begin
            steps_reg <= steps_reg + hptd_pkg::STEP_W'(1);
        end
        if (cmd.step_ev && !stat.self_parent)
        begin
            if (stat.ptab_none)
            begin
                root_reg <= v_reg;
            end
            else
            begin
                prev_reg <= {1'b1, v_reg};
                v_reg    <= ptab_q;
            end
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status;
        end
        if (cmd.dec_start)
        begin
            bit_reg <= 3'd0;
        end
        else if (cmd.dec_step)
        begin
            bit_reg <= bit_reg + 3'd1;
        end
        if (out_free)
        begin
            out_kind_reg <= cmd.finish;
            out_sym_reg  <= cmd.finish ? 8'd0 : dec_child[7:0];
            out_st_reg   <= cmd.finish ? status_reg : hptd_pkg::ST_OK;
            out_last_reg <= cmd.finish || stat.sym_one;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tree_ready_reg <= 1'b0;
            sym_left_reg   <= 31'd0;
            walk_node_reg  <= hptd_pkg::ROOT_SLOT;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                tree_ready_reg <= (status_reg == hptd_pkg::ST_OK);
                sym_left_reg   <= (status_reg == hptd_pkg::ST_OK) ? total_reg : 31'd0;
                walk_node_reg  <= hptd_pkg::ROOT_SLOT;
            end
            else if (cmd.dec_step)
            begin
                walk_node_reg <= dec_next;
                if (cmd.dec_emit)
                begin
                    sym_left_reg <= sym_left_reg - 31'd1;
                end
            end
            if (out_free)
            begin
                out_valid_reg <= cmd.finish || cmd.dec_emit;
            end
        end
    end

    assign res_valid    = out_valid_reg;
    assign result_kind  = out_kind_reg;
    assign symbol       = out_sym_reg;
    assign build_status = out_st_reg;
    assign last         = out_last_reg;

endmodule

### src/huffman_parent_table_decoder_unit.sv
// ----------------------------------------------------------------------------
// huffman_parent_table_decoder_unit
// Huffman decoder built from a loaded parent table; decodes bytes LSB first.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  request  | req_valid / req_ready | req_type, entry_index, payload_byte,
//           |                       | symbol_total
//  result   | res_valid / res_ready | result_kind, symbol, build_status, last
//
// Data byte: one tree step per bit through the child-pair memory port. Build:
// a table read and check per leaf, a read and a write per chain step.
// Reset clears control state only; the parent table is undefined until loaded.
// A stalled result register holds the sequencer before each new item.
// ----------------------------------------------------------------------------
module huffman_parent_table_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [1:0]  req_type,
    input  logic [8:0]  entry_index,
    input  logic [7:0]  payload_byte,
    input  logic [30:0] symbol_total,
    output logic        res_valid,
    input  logic        res_ready,
    output logic        result_kind,
    output logic [7:0]  symbol,
    output logic [1:0]  build_status,
    output logic        last
);

    hptd_pkg::hptd_cmd_t  cmd;
    hptd_pkg::hptd_stat_t stat;

    hptd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_type  (req_type),
        .stat      (stat),
        .cmd       (cmd)
    );

    hptd_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .req_type     (req_type),
        .entry_index  (entry_index),
        .payload_byte (payload_byte),
        .symbol_total (symbol_total),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .result_kind  (result_kind),
        .symbol       (symbol),
        .build_status (build_status),
        .last         (last)
    );

endmodule
